// File: rtl/core/mandelbrot_escape_time_pixel_macros.svh
// Assertion macros used by the checker file of the escape-time pixel block.
// Depends on a clk and an arst_n signal in the scope of each use.
`ifndef MANDELBROT_ESCAPE_TIME_PIXEL_MACROS_SVH
`define MANDELBROT_ESCAPE_TIME_PIXEL_MACROS_SVH

// Same-cycle implication, checked outside reset
`define MEP_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("mep check failed: same-cycle implication");

// Next-cycle implication, checked outside reset
`define MEP_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("mep check failed: next-cycle implication");

`endif

// File: rtl/core/mep_pkg.sv
// Shared types and constants of the escape-time pixel block.
// No dependencies; imported by the top level, mep_front, mep_queue and mep_back.
`default_nettype none

package mep_pkg;

	// default sizes
	localparam int COORD_BITS_DEF = 12;
	localparam int FRAC_BITS_DEF  = 27;

	// depth of the queue between the coordinate mapper and the iteration engine
	localparam int QUEUE_DEPTH = 2;

	// register indexes of the write port
	typedef enum logic [7:0] {
		REG_REAL_START = 8'd0,
		REG_IMAG_START = 8'd1,
		REG_REAL_STEP  = 8'd2,
		REG_IMAG_STEP  = 8'd3,
		REG_ITER_LIMIT = 8'd4
	} reg_idx_t;

	// register reset values
	localparam logic signed [31:0] REAL_START_RST = -32'sd281857229;
	localparam logic signed [31:0] IMAG_START_RST = 32'sd174483046;
	localparam logic [30:0]        REAL_STEP_RST  = 31'd651135;
	localparam logic [30:0]        IMAG_STEP_RST  = 31'd728530;
	localparam logic [15:0]        ITER_LIMIT_RST = 16'd1000;

	// mapped point c, both parts signed fixed point
	typedef struct packed {
		logic signed [31:0] cre;
		logic signed [31:0] cim;
	} point_t;

	// queue status seen by both sides
	typedef struct packed {
		logic empty;
		logic full;
	} q_stat_t;

endpackage

`default_nettype wire

// File: rtl/core/mandelbrot_escape_time_pixel.sv
// Escape-time evaluator for one pixel coordinate per request.
// Channels: input queue side (push/full) takes column and line; result queue
// side (empty/pop) gives red_level, inside_set and escape_count of the oldest
// pixel; a write port (wr_en/wr_index/wr_data) sets the five window and
// limit registers, which the user must write only while no pixel is in
// flight; the block itself does not enforce this. Path: a capture stage and
// a multiply stage in the front map the coordinate through one 43-bit
// multiply per part, the two-entry queue passes it into the iteration
// engine, then each iteration has a multiply state for the three 32x32
// products and an update state for the escape compare and the z update.
// The final decision is taken in the update state after an escape and in
// the multiply state at the limit.
// Throughput: the single iteration engine works on one pixel at a time and
// takes the next point only after the result is popped; the front keeps
// taking up to four requests while it works.
// Reset: registers return to the default window and a limit of 1000, the
// queue and front stages empty. A stalled result stays on the ports until
// popped; the front then fills and raises full.
// Depends on mep_pkg, mep_front, mep_queue, mep_back.
`default_nettype none

module mandelbrot_escape_time_pixel #(
	parameter int COORD_BITS = mep_pkg::COORD_BITS_DEF,
	parameter int FRAC_BITS  = mep_pkg::FRAC_BITS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  push,
	output logic                       full,
	input  wire logic [COORD_BITS-1:0] column,
	input  wire logic [COORD_BITS-1:0] line,
	output logic                       empty,
	input  wire logic                  pop,
	output logic [7:0]                 red_level,
	output logic                       inside_set,
	output logic [15:0]                escape_count,
	input  wire logic                  wr_en,
	input  wire logic [7:0]            wr_index,
	input  wire logic [31:0]           wr_data
);
	import mep_pkg::*;

	logic signed [31:0] real_start_q, imag_start_q;
	logic [30:0]        real_step_q, imag_step_q;
	logic [15:0]        iter_limit_q;

	q_stat_t q_stat;
	point_t  q_wr_pt, q_rd_pt;
	logic    q_push, q_pop;

	// configuration registers; unknown indexes are ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			real_start_q <= REAL_START_RST;
			imag_start_q <= IMAG_START_RST;
			real_step_q  <= REAL_STEP_RST;
			imag_step_q  <= IMAG_STEP_RST;
			iter_limit_q <= ITER_LIMIT_RST;
		end else if (wr_en) begin
			if (wr_index == REG_REAL_START) real_start_q <= wr_data;
			if (wr_index == REG_IMAG_START) imag_start_q <= wr_data;
			if (wr_index == REG_REAL_STEP)  real_step_q  <= wr_data[30:0];
			if (wr_index == REG_IMAG_STEP)  imag_step_q  <= wr_data[30:0];
			if (wr_index == REG_ITER_LIMIT) iter_limit_q <= wr_data[15:0];
		end
	end

	mep_front #(.COORD_BITS(COORD_BITS)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.column     (column),
		.line       (line),
		.real_start (real_start_q),
		.imag_start (imag_start_q),
		.real_step  (real_step_q),
		.imag_step  (imag_step_q),
		.q_stat     (q_stat),
		.q_push     (q_push),
		.q_data     (q_wr_pt)
	);

	mep_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (q_push),
		.wr_pt  (q_wr_pt),
		.rd     (q_pop),
		.rd_pt  (q_rd_pt),
		.stat   (q_stat)
	);

	mep_back #(.FRAC_BITS(FRAC_BITS)) u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.q_stat          (q_stat),
		.q_data          (q_rd_pt),
		.q_pop           (q_pop),
		.iteration_limit (iter_limit_q),
		.empty           (empty),
		.pop             (pop),
		.red_level       (red_level),
		.inside_set      (inside_set),
		.escape_count    (escape_count)
	);

endmodule

`default_nettype wire

// File: rtl/core/mep_front.sv
// Front part: accepts pixel requests and maps them to points of the plane.
// Depends on mep_pkg; feeds mep_queue.
`default_nettype none

module mep_front #(
	parameter int COORD_BITS = mep_pkg::COORD_BITS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  push,
	output logic                       full,
	input  wire logic [COORD_BITS-1:0] column,
	input  wire logic [COORD_BITS-1:0] line,
	input  wire logic signed [31:0]    real_start,
	input  wire logic signed [31:0]    imag_start,
	input  wire logic [30:0]           real_step,
	input  wire logic [30:0]           imag_step,
	input  wire mep_pkg::q_stat_t      q_stat,
	output logic                       q_push,
	output mep_pkg::point_t            q_data
);
	import mep_pkg::*;

	localparam int PW = COORD_BITS + 31;
	localparam int SW = PW + 2;
	localparam logic signed [SW-1:0] SAT_HI = SW'(64'sh7FFF_FFFF);
	localparam logic signed [SW-1:0] SAT_LO = -SAT_HI - SW'(1);

	logic                  v_s1, v_s2;
	logic [COORD_BITS-1:0] col_s1, row_s1;
	logic [PW-1:0]         pre_s2, pim_s2;
	logic                  s1_adv, s2_adv;
	logic signed [SW-1:0]  sum_re, sum_im;

	// stall chain
	assign s2_adv = !v_s2 || !q_stat.full;
	assign s1_adv = !v_s1 || s2_adv;
	assign full   = !s1_adv;
	assign q_push = v_s2 && !q_stat.full;

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (s1_adv) v_s1 <= push;
			if (s2_adv) v_s2 <= v_s1;
		end
	end

	// payload: capture, then one multiply per part
	always_ff @(posedge clk) begin
		if (push && s1_adv) begin
			col_s1 <= column;
			row_s1 <= line;
		end
		if (v_s1 && s2_adv) begin
			pre_s2 <= PW'(col_s1) * PW'(real_step);
			pim_s2 <= PW'(row_s1) * PW'(imag_step);
		end
	end

	// offset from the start point and clamp to 32 bits
	always_comb begin
		sum_re = SW'(real_start) + $signed({2'b00, pre_s2});
		sum_im = SW'(imag_start) - $signed({2'b00, pim_s2});
		if (sum_re > SAT_HI)      q_data.cre = 32'sh7FFF_FFFF;
		else if (sum_re < SAT_LO) q_data.cre = 32'sh8000_0000;
		else                      q_data.cre = sum_re[31:0];
		if (sum_im > SAT_HI)      q_data.cim = 32'sh7FFF_FFFF;
		else if (sum_im < SAT_LO) q_data.cim = 32'sh8000_0000;
		else                      q_data.cim = sum_im[31:0];
	end

endmodule

`default_nettype wire

// File: rtl/core/mep_queue.sv
// Short flip-flop queue of mapped points between front and back.
// Depends on mep_pkg.
`default_nettype none

module mep_queue #(
	parameter int DEPTH = mep_pkg::QUEUE_DEPTH
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            wr,
	input  wire mep_pkg::point_t wr_pt,
	input  wire logic            rd,
	output mep_pkg::point_t      rd_pt,
	output mep_pkg::q_stat_t     stat
);
	import mep_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	point_t        slot_q [DEPTH];
	logic [AW-1:0] wp_q, rp_q;
	logic [CW-1:0] cnt_q;

	assign stat.empty = (cnt_q == CW'(0));
	assign stat.full  = (cnt_q == CW'(DEPTH));
	assign rd_pt      = slot_q[rp_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (wr) wp_q <= (wp_q == AW'(DEPTH - 1)) ? '0 : wp_q + AW'(1);
			if (rd) rp_q <= (rp_q == AW'(DEPTH - 1)) ? '0 : rp_q + AW'(1);
			if (wr && !rd)      cnt_q <= cnt_q + CW'(1);
			else if (rd && !wr) cnt_q <= cnt_q - CW'(1);
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (wr) slot_q[wp_q] <= wr_pt;
	end

endmodule

`default_nettype wire

// File: rtl/core/mep_back.sv
// Back part: iterates z = z^2 + c for one point and holds its result.
// Depends on mep_pkg; fed by mep_queue.
`default_nettype none

module mep_back #(
	parameter int FRAC_BITS = mep_pkg::FRAC_BITS_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire mep_pkg::q_stat_t q_stat,
	input  wire mep_pkg::point_t  q_data,
	output logic                  q_pop,
	input  wire logic [15:0]      iteration_limit,
	output logic                  empty,
	input  wire logic             pop,
	output logic [7:0]            red_level,
	output logic                  inside_set,
	output logic [15:0]           escape_count
);
	import mep_pkg::*;

	localparam logic [63:0] ESC_BOUND = 64'd4 << (2 * FRAC_BITS);

	typedef enum logic [1:0] {ST_IDLE, ST_MUL, ST_UPD, ST_DONE} state_t;

	state_t             state_q;
	logic signed [31:0] cre_q, cim_q, x_q, y_q;
	logic signed [63:0] xx_q, yy_q, xy_q;
	logic [15:0]        iter_q, count_q;
	logic               inside_q;

	logic               esc;
	logic signed [63:0] diff, dbl, dsh, ysh;
	logic signed [33:0] xs, ys;
	logic signed [31:0] x_nx, y_nx;

	function automatic logic signed [31:0] clamp34(input logic signed [33:0] v);
		if (v > 34'sh0_7FFF_FFFF)      return 32'sh7FFF_FFFF;
		else if (v < -34'sh0_8000_0000) return 32'sh8000_0000;
		else                            return v[31:0];
	endfunction

	// escape test and next z from the registered products
	always_comb begin
		esc  = ($unsigned(xx_q) + $unsigned(yy_q)) >= ESC_BOUND;
		diff = xx_q - yy_q;
		dbl  = xy_q <<< 1;
		dsh  = diff >>> FRAC_BITS;
		ysh  = dbl >>> FRAC_BITS;
		xs   = $signed(dsh[33:0]) + 34'(cre_q);
		ys   = $signed(ysh[33:0]) + 34'(cim_q);
		x_nx = clamp34(xs);
		y_nx = clamp34(ys);
	end

	assign q_pop        = (state_q == ST_IDLE) && !q_stat.empty;
	assign empty        = (state_q != ST_DONE);
	assign inside_set   = inside_q;
	assign escape_count = count_q;
	assign red_level    = inside_q ? 8'd0 : {count_q[5:0], 2'b00};

	// sequencer: load, multiply, update, hold result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (!q_stat.empty) begin
						cre_q   <= q_data.cre;
						cim_q   <= q_data.cim;
						x_q     <= q_data.cre;
						y_q     <= q_data.cim;
						iter_q  <= '0;
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					if (iter_q == iteration_limit) begin
						inside_q <= 1'b1;
						count_q  <= iter_q;
						state_q  <= ST_DONE;
					end else begin
						xx_q    <= x_q * x_q;
						yy_q    <= y_q * y_q;
						xy_q    <= x_q * y_q;
						state_q <= ST_UPD;
					end
				end
				ST_UPD: begin
					if (esc) begin
						inside_q <= 1'b0;
						count_q  <= iter_q;
						state_q  <= ST_DONE;
					end else begin
						x_q     <= x_nx;
						y_q     <= y_nx;
						iter_q  <= iter_q + 16'd1;
						state_q <= ST_MUL;
					end
				end
				ST_DONE: begin
					if (pop) state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// File: rtl/core/mep_checker.sv
// Port-level checks of the escape-time pixel block, bound to its top level.
// Depends on mandelbrot_escape_time_pixel_macros.svh.
`default_nettype none

`include "mandelbrot_escape_time_pixel_macros.svh"

module mep_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        empty,
	input wire logic        pop,
	input wire logic [7:0]  red_level,
	input wire logic        inside_set,
	input wire logic [15:0] escape_count
);

	// a waiting result holds until it is popped
	`MEP_ASSERT_NEXT(a_result_holds, !empty && !pop, !empty && $stable(red_level) && $stable(inside_set) && $stable(escape_count))

	// red level follows the count, zero inside the set
	`MEP_ASSERT_IMPL(a_red_matches, !empty, red_level == (inside_set ? 8'd0 : {escape_count[5:0], 2'b00}))

	// an escaped point ran fewer than the largest possible limit
	`MEP_ASSERT_IMPL(a_escape_below_max, !empty && !inside_set, escape_count != 16'hFFFF)

endmodule

bind mandelbrot_escape_time_pixel mep_checker u_mep_checker (.*);

`default_nettype wire
